[src/glvl_pkg.sv]
`timescale 1ns / 1ps
package glvl_pkg;

  localparam int MAX_GATES = 64;
  localparam int ID_BITS   = 16;
  localparam int LVL_BITS  = 6;
  localparam logic [LVL_BITS-1:0] LVL_MAX = 6'd63;

  typedef struct packed {
    logic clr;
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

[src/glvl_cell.sv]
`timescale 1ns / 1ps
module glvl_cell #(
  parameter int ID_BITS = glvl_pkg::ID_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  glvl_pkg::cell_ctl_t          ctl_i,
  input  logic [ID_BITS-1:0]           nxt_id_i,
  input  logic [ID_BITS-1:0]           nxt_da_i,
  input  logic [ID_BITS-1:0]           nxt_db_i,
  input  logic                         nxt_pr_i,
  input  logic [glvl_pkg::LVL_BITS-1:0] nxt_lv_i,
  input  logic                         nxt_rs_i,
  input  logic                         nxt_us_i,
  input  logic [ID_BITS-1:0]           ld_id_i,
  input  logic [ID_BITS-1:0]           ld_da_i,
  input  logic [ID_BITS-1:0]           ld_db_i,
  input  logic                         ld_pr_i,
  output logic [ID_BITS-1:0]           id_o,
  output logic [ID_BITS-1:0]           da_o,
  output logic [ID_BITS-1:0]           db_o,
  output logic                         pr_o,
  output logic [glvl_pkg::LVL_BITS-1:0] lv_o,
  output logic                         rs_o,
  output logic                         us_o
);

  logic [ID_BITS-1:0]            id_q, da_q, db_q;
  logic                          pr_q, rs_q, us_q;
  logic [glvl_pkg::LVL_BITS-1:0] lv_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      id_q <= ld_id_i;
      da_q <= ld_da_i;
      db_q <= ld_db_i;
      pr_q <= ld_pr_i;
      lv_q <= '0;
    end else if (ctl_i.shift) begin
      id_q <= nxt_id_i;
      da_q <= nxt_da_i;
      db_q <= nxt_db_i;
      pr_q <= nxt_pr_i;
      lv_q <= nxt_lv_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      us_q <= 1'b0;
      rs_q <= 1'b0;
    end else if (ctl_i.clr) begin
      us_q <= 1'b0;
      rs_q <= 1'b0;
    end else if (ctl_i.load) begin
      us_q <= 1'b1;
      rs_q <= 1'b0;
    end else if (ctl_i.shift) begin
      us_q <= nxt_us_i;
      rs_q <= nxt_rs_i;
    end
  end

  assign id_o = id_q;
  assign da_o = da_q;
  assign db_o = db_q;
  assign pr_o = pr_q;
  assign lv_o = lv_q;
  assign rs_o = rs_q;
  assign us_o = us_q;

endmodule

[src/gate_netlist_levelizer_unit.sv]
`timescale 1ns / 1ps
// Netlist levelizer. Input channel (in_valid_i/in_ready_o) takes one gate record per
// cycle while idle; records beyond MAX_GATES are dropped. A record with last_record_i
// starts levelization; in_ready_o stays low until every gate has been emitted.
// Gates sit in a ring of MAX_GATES cells. During levelization and emission the ring
// rotates one position per cycle, except when a driver lookup starts (ST_STEP) and
// while the receiver stalls. Each pass visits every cell; an unresolved non-primary
// gate takes one full rotation (ST_SCAN, then ST_FIN) to look up its drivers, every
// other cell a single shift. Passes repeat until one resolves nothing.
// Emission sweeps the ring once per level (64 levels) and once more for unresolved
// gates: results in ascending level, ties in load order, unresolved gates last with
// level 0. last_of_run_o marks the final result of a run.
// Output channel (out_valid_o/out_ready_i) has a single output register; while
// the receiver stalls, the ring holds. Reset empties the table and drops any
// pending result; no clearing pass is needed.
module gate_netlist_levelizer_unit #(
  parameter int MAX_GATES = glvl_pkg::MAX_GATES,
  parameter int ID_BITS   = glvl_pkg::ID_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] gate_id_i,
  input  logic [15:0] driver_a_i,
  input  logic [15:0] driver_b_i,
  input  logic        is_primary_input_i,
  input  logic        last_record_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_gate_id_o,
  output logic [15:0] out_driver_a_o,
  output logic [15:0] out_driver_b_o,
  output logic        out_primary_o,
  output logic [5:0]  level_o,
  output logic        unresolved_o,
  output logic        last_of_run_o
);

  localparam int IW = $clog2(MAX_GATES);
  localparam int CW = $clog2(MAX_GATES + 1);
  localparam int LW = glvl_pkg::LVL_BITS;
  localparam logic [IW-1:0] LastIdx = IW'(MAX_GATES - 1);
  localparam logic [CW-1:0] FullCnt = CW'(MAX_GATES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_STEP = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [ID_BITS-1:0] c_id [MAX_GATES];
  logic [ID_BITS-1:0] c_da [MAX_GATES];
  logic [ID_BITS-1:0] c_db [MAX_GATES];
  logic               c_pr [MAX_GATES];
  logic [LW-1:0]      c_lv [MAX_GATES];
  logic               c_rs [MAX_GATES];
  logic               c_us [MAX_GATES];

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      emit_cnt_q, emit_cnt_d;
  logic [IW-1:0]      i_q, i_d;
  logic [IW-1:0]      j_q, j_d;
  logic               changed_q, changed_d;
  logic [ID_BITS-1:0] da_q, da_d, db_q, db_d;
  logic               ka_q, ka_d, kb_q, kb_d;
  logic [LW-1:0]      la_q, la_d, lb_q, lb_d;
  logic [LW-1:0]      lvl_q, lvl_d;
  logic               phase_q, phase_d;

  logic               in_fire, out_free, out_load;
  logic               shift, clr, wr, adv, pass_chg;
  logic [LW-1:0]      wr_lvl, max_ab, new_lvl;
  logic               hit_a, hit_b, emit_match;
  logic               out_valid_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign hit_a   = c_us[0] && c_rs[0] && (c_id[0] == da_q);
  assign hit_b   = c_us[0] && c_rs[0] && (c_id[0] == db_q);
  assign max_ab  = (la_q > lb_q) ? la_q : lb_q;
  assign new_lvl = (max_ab == glvl_pkg::LVL_MAX) ? max_ab : max_ab + LW'(1);
  assign emit_match = c_us[0] && (phase_q ? !c_rs[0] : (c_rs[0] && (c_lv[0] == lvl_q)));

  for (genvar k = 0; k < MAX_GATES; k++) begin : g_ring
    glvl_pkg::cell_ctl_t ctl;
    logic [ID_BITS-1:0]  n_id, n_da, n_db;
    logic                n_pr, n_rs, n_us;
    logic [LW-1:0]       n_lv;

    assign ctl.clr   = clr;
    assign ctl.shift = shift;
    assign ctl.load  = in_fire && (count_q == CW'(k));

    if (k == MAX_GATES - 1) begin : g_tail
      assign n_id = c_id[0];
      assign n_da = c_da[0];
      assign n_db = c_db[0];
      assign n_pr = c_pr[0];
      assign n_us = c_us[0];
      assign n_rs = wr ? 1'b1 : c_rs[0];
      assign n_lv = wr ? wr_lvl : c_lv[0];
    end else begin : g_mid
      assign n_id = c_id[k+1];
      assign n_da = c_da[k+1];
      assign n_db = c_db[k+1];
      assign n_pr = c_pr[k+1];
      assign n_us = c_us[k+1];
      assign n_rs = c_rs[k+1];
      assign n_lv = c_lv[k+1];
    end

    glvl_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .nxt_id_i (n_id),
      .nxt_da_i (n_da),
      .nxt_db_i (n_db),
      .nxt_pr_i (n_pr),
      .nxt_lv_i (n_lv),
      .nxt_rs_i (n_rs),
      .nxt_us_i (n_us),
      .ld_id_i  (ID_BITS'(32'(gate_id_i))),
      .ld_da_i  (ID_BITS'(32'(driver_a_i))),
      .ld_db_i  (ID_BITS'(32'(driver_b_i))),
      .ld_pr_i  (is_primary_input_i),
      .id_o     (c_id[k]),
      .da_o     (c_da[k]),
      .db_o     (c_db[k]),
      .pr_o     (c_pr[k]),
      .lv_o     (c_lv[k]),
      .rs_o     (c_rs[k]),
      .us_o     (c_us[k])
    );
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    emit_cnt_d = emit_cnt_q;
    i_d        = i_q;
    j_d        = j_q;
    changed_d  = changed_q;
    da_d       = da_q;
    db_d       = db_q;
    ka_d       = ka_q;
    kb_d       = kb_q;
    la_d       = la_q;
    lb_d       = lb_q;
    lvl_d      = lvl_q;
    phase_d    = phase_q;
    shift      = 1'b0;
    clr        = 1'b0;
    wr         = 1'b0;
    wr_lvl     = '0;
    adv        = 1'b0;
    out_load   = 1'b0;
    pass_chg   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (count_q != FullCnt) begin
            count_d = count_q + CW'(1);
          end
          if (last_record_i) begin
            state_d   = ST_STEP;
            i_d       = '0;
            changed_d = 1'b0;
          end
        end
      end
      ST_STEP: begin
        if (!c_us[0] || c_rs[0]) begin
          shift = 1'b1;
          adv   = 1'b1;
        end else if (c_pr[0]) begin
          shift     = 1'b1;
          wr        = 1'b1;
          changed_d = 1'b1;
          adv       = 1'b1;
        end else begin
          da_d    = c_da[0];
          db_d    = c_db[0];
          ka_d    = (c_da[0] == '0);
          kb_d    = (c_db[0] == '0);
          la_d    = '0;
          lb_d    = '0;
          j_d     = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift = 1'b1;
        if (hit_a) begin
          ka_d = 1'b1;
          if (c_lv[0] > la_q) begin
            la_d = c_lv[0];
          end
        end
        if (hit_b) begin
          kb_d = 1'b1;
          if (c_lv[0] > lb_q) begin
            lb_d = c_lv[0];
          end
        end
        if (j_q == LastIdx) begin
          j_d     = '0;
          state_d = ST_FIN;
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      ST_FIN: begin
        shift   = 1'b1;
        state_d = ST_STEP;
        adv     = 1'b1;
        if (ka_q && kb_q) begin
          wr        = 1'b1;
          wr_lvl    = new_lvl;
          changed_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          shift = 1'b1;
          if (emit_match) begin
            out_load   = 1'b1;
            emit_cnt_d = emit_cnt_q + CW'(1);
          end
          if (j_q == LastIdx) begin
            j_d = '0;
            if (!phase_q) begin
              if (lvl_q == glvl_pkg::LVL_MAX) begin
                phase_d = 1'b1;
              end else begin
                lvl_d = lvl_q + LW'(1);
              end
            end else begin
              clr        = 1'b1;
              count_d    = '0;
              emit_cnt_d = '0;
              state_d    = ST_IDLE;
            end
          end else begin
            j_d = j_q + IW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (adv) begin
      if (i_q == LastIdx) begin
        pass_chg = changed_d;
        i_d      = '0;
        if (pass_chg) begin
          changed_d = 1'b0;
          state_d   = ST_STEP;
        end else begin
          lvl_d   = '0;
          phase_d = 1'b0;
          j_d     = '0;
          state_d = ST_EMIT;
        end
      end else begin
        i_d = i_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      emit_cnt_q  <= '0;
      i_q         <= '0;
      j_q         <= '0;
      changed_q   <= 1'b0;
      ka_q        <= 1'b0;
      kb_q        <= 1'b0;
      lvl_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      emit_cnt_q <= emit_cnt_d;
      i_q        <= i_d;
      j_q        <= j_d;
      changed_q  <= changed_d;
      ka_q       <= ka_d;
      kb_q       <= kb_d;
      lvl_q      <= lvl_d;
      phase_q    <= phase_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    da_q <= da_d;
    db_q <= db_d;
    la_q <= la_d;
    lb_q <= lb_d;
    if (out_load) begin
      out_gate_id_o  <= 16'(32'(c_id[0]));
      out_driver_a_o <= 16'(32'(c_da[0]));
      out_driver_b_o <= 16'(32'(c_db[0]));
      out_primary_o  <= c_pr[0];
      level_o        <= phase_q ? '0 : c_lv[0];
      unresolved_o   <= phase_q;
      last_of_run_o  <= (emit_cnt_q == count_q - CW'(1));
    end
  end

  assign out_valid_o = out_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("gate count above table size");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (emit_cnt_q <= count_q) && (count_q != '0))
    else $error("emitted more gates than loaded");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (emit_cnt_q == '0))
    else $error("emit counter not cleared at end of run");

  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && state_d == ST_IDLE) |-> (emit_cnt_d == '0) && clr)
    else $error("run ended without clearing the table");

endmodule

[bench/tb_gate_netlist_levelizer_unit.sv]
`timescale 1ns / 1ps
module tb_gate_netlist_levelizer_unit;

  localparam int MAX_GATES = glvl_pkg::MAX_GATES;
  localparam int LVL_BITS = glvl_pkg::LVL_BITS;
  localparam logic [LVL_BITS-1:0] LVL_MAX = glvl_pkg::LVL_MAX;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int DRAIN_CYCLES = 5000;

  typedef struct {
    logic [15:0] id;
    logic [15:0] drv_a;
    logic [15:0] drv_b;
    logic        prim;
  } gate_rec_t;

  typedef struct {
    logic [15:0]         id;
    logic [15:0]         drv_a;
    logic [15:0]         drv_b;
    logic                prim;
    logic [LVL_BITS-1:0] lvl;
    logic                unres;
    logic                last;
  } emitted_gate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [15:0] gate_id_i = '0;
  logic [15:0] driver_a_i = '0;
  logic [15:0] driver_b_i = '0;
  logic is_primary_input_i = 1'b0;
  logic last_record_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] out_gate_id_o;
  logic [15:0] out_driver_a_o;
  logic [15:0] out_driver_b_o;
  logic out_primary_o;
  logic [5:0] level_o;
  logic unresolved_o;
  logic last_of_run_o;

  gate_rec_t     table_q[$];
  emitted_gate_t order_q[$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  gate_netlist_levelizer_unit dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic int driver_level(logic [15:0] id, int lvls[MAX_GATES],
                                      bit done[MAX_GATES]);
    int best;
    best = (id == 16'd0) ? 0 : -1;
    for (int k = 0; k < table_q.size(); k++)
      if (done[k] && table_q[k].id == id && lvls[k] > best) best = lvls[k];
    return best;
  endfunction

  task automatic levelize_and_order();
    int lvls[MAX_GATES];
    bit done[MAX_GATES];
    bit changed;
    int la, lb, m;
    emitted_gate_t r;
    for (int i = 0; i < MAX_GATES; i++) begin
      lvls[i] = 0;
      done[i] = 1'b0;
    end
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int i = 0; i < table_q.size(); i++) begin
        if (done[i]) continue;
        if (table_q[i].prim) begin
          lvls[i] = 0;
          done[i] = 1'b1;
          changed = 1'b1;
          continue;
        end
        la = driver_level(table_q[i].drv_a, lvls, done);
        lb = driver_level(table_q[i].drv_b, lvls, done);
        if (la < 0 || lb < 0) continue;
        m = ((la > lb) ? la : lb) + 1;
        if (m > int'(LVL_MAX)) m = int'(LVL_MAX);
        lvls[i] = m;
        done[i] = 1'b1;
        changed = 1'b1;
      end
    end
    for (int l = 0; l <= int'(LVL_MAX); l++)
      for (int i = 0; i < table_q.size(); i++)
        if (done[i] && lvls[i] == l) begin
          r = '{table_q[i].id, table_q[i].drv_a, table_q[i].drv_b, table_q[i].prim,
                LVL_BITS'(l), 1'b0, 1'b0};
          order_q.insert(order_q.size(), r);
        end
    for (int i = 0; i < table_q.size(); i++)
      if (!done[i]) begin
        r = '{table_q[i].id, table_q[i].drv_a, table_q[i].drv_b, table_q[i].prim,
              '0, 1'b1, 1'b0};
        order_q.insert(order_q.size(), r);
      end
    if (table_q.size() > 0) order_q[order_q.size()-1].last = 1'b1;
    table_q.delete();
  endtask

  task automatic send_gate(logic [15:0] id, logic [15:0] a, logic [15:0] b,
                           logic prim, logic last);
    gate_rec_t g;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    gate_id_i <= id;
    driver_a_i <= a;
    driver_b_i <= b;
    is_primary_input_i <= prim;
    last_record_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    g = '{id, a, b, prim};
    if (table_q.size() < MAX_GATES) table_q.insert(table_q.size(), g);
    if (last) levelize_and_order();
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (order_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    emitted_gate_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (order_q.size() == 0) begin
        report_mismatch("unexpected transfer, gate", out_gate_id_o, 0);
      end else begin
        e = order_q.pop_front();
        if (out_gate_id_o !== e.id) report_mismatch("gate id", out_gate_id_o, e.id);
        if (out_driver_a_o !== e.drv_a) report_mismatch("driver a", out_driver_a_o, e.drv_a);
        if (out_driver_b_o !== e.drv_b) report_mismatch("driver b", out_driver_b_o, e.drv_b);
        if (out_primary_o !== e.prim) report_mismatch("primary", out_primary_o, e.prim);
        if (level_o !== e.lvl) report_mismatch("level", level_o, e.lvl);
        if (unresolved_o !== e.unres) report_mismatch("unresolved", unresolved_o, e.unres);
        if (last_of_run_o !== e.last) report_mismatch("last of run", last_of_run_o, e.last);
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** gate_netlist_levelizer_unit: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    send_gate(16'd1, 16'd0, 16'd0, 1'b1, 1'b1);
    send_gate(16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_gate(16'd5, 16'd0, 16'd0, 1'b0, 1'b0);
    send_gate(16'hFFFF, 16'd5, 16'd0, 1'b0, 1'b0);
    send_gate(16'd7, 16'hFFFF, 16'd5, 1'b0, 1'b0);
    send_gate(16'd5, 16'd7, 16'd7, 1'b0, 1'b0);
    send_gate(16'd9, 16'd5, 16'd0, 1'b0, 1'b0);
    send_gate(16'd2, 16'd3, 16'd0, 1'b0, 1'b0);
    send_gate(16'd3, 16'd2, 16'd0, 1'b0, 1'b0);
    send_gate(16'd4, 16'd1234, 16'd0, 1'b0, 1'b0);
    send_gate(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_gate(16'd8, 16'd8, 16'd0, 1'b0, 1'b1);
  endtask

  task automatic test_full_table();
    for (int k = 1; k <= MAX_GATES; k++)
      send_gate(16'(k), 16'(k - 1), (k % 3 == 0) ? 16'(k - 2) : 16'd0, 1'b0, 1'b0);
    send_gate(16'hAAAA, 16'd0, 16'd0, 1'b1, 1'b0);
    send_gate(16'h5555, 16'd0, 16'd0, 1'b0, 1'b1);
  endtask

  task automatic random_netlist(int n);
    logic [15:0] base;
    logic [15:0] ids[$];
    int order[$];
    int j, t;
    bit noisy;
    logic [15:0] a, b;
    base = 16'($urandom);
    noisy = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < n; k++) begin
      ids.insert(ids.size(), base + 16'(k));
      order.insert(order.size(), k);
    end
    if (n <= 12 && $urandom_range(0, 2) == 0)
      for (int k = n - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = order[k];
        order[k] = order[j];
        order[j] = t;
      end
    for (int k = 0; k < n; k++) begin
      j = order[k];
      if (noisy) begin
        a = ($urandom_range(0, 1) != 0) ? 16'($urandom) : ids[$urandom_range(0, n - 1)];
        b = ids[$urandom_range(0, n - 1)];
      end else begin
        a = (j == 0 || $urandom_range(0, 4) == 0) ? 16'd0 : ids[$urandom_range(0, j - 1)];
        b = (j == 0 || $urandom_range(0, 2) == 0) ? 16'd0 : ids[$urandom_range(0, j - 1)];
      end
      send_gate(ids[j], a, b, j == 0 || $urandom_range(0, 5) == 0, k == n - 1);
    end
  endtask

  task automatic test_random(int target);
    while (items_sent < target)
      random_netlist(($urandom_range(0, 9) == 0) ? $urandom_range(20, 32)
                                                 : $urandom_range(1, 10));
  endtask

  task automatic test_backpressure();
    hold_left = 600;
    random_netlist(8);
    random_netlist(6);
  endtask

  task automatic test_sender_pause();
    random_netlist(5);
    wait_drained();
    repeat (20) @(negedge clk_i);
    random_netlist(4);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_table();
    test_backpressure();
    test_sender_pause();
    test_random(340);
    quiet = 1'b1;
    test_random(420);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && order_q.size() == 0) begin
      $display("** gate_netlist_levelizer_unit: PASSED **");
    end else begin
      $display("** gate_netlist_levelizer_unit: FAILED **");
    end
    $finish;
  end

endmodule
